/* design/stable_priority_queue_top_assert.svh */
// Assertion macros for the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, ignored while reset is low.
`define SPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/spq_pkg.sv */
package spq_pkg;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_FRONT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

/* design/spq_cell.sv */
module spq_cell #(
  parameter int DATA_BITS     = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctrl_t      ctrl,
  input  logic                     occupied,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [DATA_BITS-1:0]     new_data,
  input  logic                     left_keep,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [DATA_BITS-1:0]     left_data,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [DATA_BITS-1:0]     right_data,
  output logic                     keep,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [DATA_BITS-1:0]     data
);

  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [DATA_BITS-1:0]     data_r, data_nxt;

  // Stay put on a push when this entry ranks at or before the new one.
  assign keep = occupied && (prio_r <= new_prio);

  always_comb begin
    prio_nxt = prio_r;
    data_nxt = data_r;
    if (ctrl.push) begin
      if (!keep && left_keep) begin
        prio_nxt = new_prio;
        data_nxt = new_data;
      end else if (!keep) begin
        prio_nxt = left_prio;
        data_nxt = left_data;
      end
    end else if (ctrl.pop) begin
      prio_nxt = right_prio;
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    data_r <= data_nxt;
  end

  assign prio = prio_r;
  assign data = data_r;

endmodule

/* design/stable_priority_queue_top.sv */
// Stable priority queue: a row of DEPTH cells kept sorted by ascending
// priority, equal priorities leaving in arrival order.
// Input channel (in_valid/in_ready): one item is one operation selected by
// in_mode: push (in_priority_req, in_payload), pop of the head, or read of
// the head. Mode three does nothing and reports ok.
// Result channel (out_valid/out_ready): exactly one item per accepted input,
// carrying the head data (zero unless a pop or read succeeded), a status
// (ok, empty on pop/read, full on a dropped push) and the occupancy after
// the operation.
// Result: registered, and shows in the cycle after acceptance.
// Throughput: one operation per cycle unless stalled; every cell compares its
// priority with the new one and shifts toward its neighbor in the same cycle,
// so the row takes a push or pop each clock while in_ready is high.
// Stall: the single output register accepts a new item in the same cycle
// that the pending result is taken; while a result waits with out_ready
// low, in_ready drops and the queue holds.
// Reset: rst_n (synchronous, active low) empties the queue and drops any
// pending result; cell contents are not cleared, only the count.
module stable_priority_queue_top #(
  parameter int DEPTH         = 16,
  parameter int DATA_BITS     = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [PRIORITY_BITS-1:0]       in_priority_req,
  input  logic [DATA_BITS-1:0]           in_payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DATA_BITS-1:0]           out_head_data,
  output logic [1:0]                     out_status,
  output logic [$clog2(DEPTH+1)-1:0]     out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r;
  logic [DATA_BITS-1:0] out_head_data_r;
  logic [1:0]           out_status_r;
  logic [CNT_W-1:0]     out_occupancy_r;

  logic                 in_fire;
  logic                 is_empty, is_full;
  spq_pkg::cell_ctrl_t  ctrl;
  logic [DATA_BITS-1:0] head_nxt;
  logic [1:0]           status_nxt;

  logic [DEPTH-1:0]         cell_keep;
  logic [DEPTH-1:0]         cell_occ;
  logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
  logic [DATA_BITS-1:0]     cell_data [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == CNT_FULL);

  // Decode the operation; drop pushes into a full row and pops of nothing.
  always_comb begin
    ctrl       = '0;
    head_nxt   = '0;
    status_nxt = spq_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    unique case (in_mode) inside
      spq_pkg::MODE_PUSH: begin
        if (is_full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          ctrl.push = in_fire;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      spq_pkg::MODE_POP, spq_pkg::MODE_FRONT: begin
        if (is_empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          head_nxt = cell_data[0];
          if (in_mode == spq_pkg::MODE_POP) begin
            ctrl.pop = in_fire;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Build the row; the cell at the head sees a virtual neighbor that keeps.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_keep;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;
    logic [DATA_BITS-1:0]     l_data, r_data;

    assign cell_occ[i] = (cnt_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_prio = in_priority_req;
      assign l_data = in_payload;
    end else begin : g_body
      assign l_keep = cell_keep[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_prio = cell_prio[i];
      assign r_data = cell_data[i];
    end else begin : g_inner
      assign r_prio = cell_prio[i+1];
      assign r_data = cell_data[i+1];
    end

    spq_cell #(
      .DATA_BITS    (DATA_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (cell_occ[i]),
      .new_prio  (in_priority_req),
      .new_data  (in_payload),
      .left_keep (l_keep),
      .left_prio (l_prio),
      .left_data (l_data),
      .right_prio(r_prio),
      .right_data(r_data),
      .keep      (cell_keep[i]),
      .prio      (cell_prio[i]),
      .data      (cell_data[i])
    );
  end

  // Hold count and result valid; the count advances only on an accepted item, valid clears when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_head_data_r <= head_nxt;
      out_status_r    <= status_nxt;
      out_occupancy_r <= cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_head_data = out_head_data_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

`include "stable_priority_queue_top_assert.svh"

  `SPQ_ASSERT_ALWAYS(a_cnt_bound, clk, !rst_n || (cnt_r <= CNT_FULL), "count exceeds depth")
  `SPQ_ASSERT_RST(a_push_grows, clk, rst_n, in_fire && in_mode == spq_pkg::MODE_PUSH && !is_full |=> cnt_r == $past(cnt_r) + CNT_W'(1), "push did not grow count")
  `SPQ_ASSERT_RST(a_full_flag, clk, rst_n, in_fire && in_mode == spq_pkg::MODE_PUSH && is_full |=> out_valid_r && out_status_r == spq_pkg::ST_FULL, "full push not flagged")
  `SPQ_ASSERT_RST(a_head_order, clk, rst_n, cnt_r >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1], "head cells out of order")

endmodule

/* tb/stable_priority_queue_top_test.sv */
`timescale 1ns / 100ps

module stable_priority_queue_top_test;

  localparam int DEPTH         = 16;
  localparam int DATA_BITS     = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int OCC_BITS      = $clog2(DEPTH + 1);

  // Mode three is not named in the package; the block treats it as a no-op.
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam int MAX_IDLE       = 12;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int SETTLE_CYCLES  = 10;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 460;

  typedef struct packed {
    logic [DATA_BITS-1:0] head_data;
    logic [1:0]           status;
    logic [OCC_BITS-1:0]  occupancy;
  } op_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_mode = MODE_NOP;
  logic [PRIORITY_BITS-1:0]  in_priority_req = '0;
  logic [DATA_BITS-1:0]      in_payload = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DATA_BITS-1:0]      out_head_data;
  logic [1:0]                out_status;
  logic [OCC_BITS-1:0]       out_occupancy;

  // Shadow copy of the sorted row, lowest priority value at index zero.
  logic [PRIORITY_BITS-1:0]  shadow_prio [DEPTH];
  logic [DATA_BITS-1:0]      shadow_data [DEPTH];
  int                        shadow_count = 0;

  op_result_t                pending_results[$];
  int                        error_count = 0;
  int                        quiet_cycles = 0;

  // Knobs shared by the stimulus tasks and the result-side process.
  bit                        send_idle_en = 1'b1;
  bit                        take_idle_en = 1'b1;
  int                        hold_off_req = 0;

  stable_priority_queue_top #(
    .DEPTH        (DEPTH),
    .DATA_BITS    (DATA_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_priority_req(in_priority_req),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_head_data  (out_head_data),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one operation to the shadow row and return what the block must report.
  function automatic op_result_t apply_queue_op(logic [1:0] mode,
                                                logic [PRIORITY_BITS-1:0] prio,
                                                logic [DATA_BITS-1:0] data);
    op_result_t r;
    int slot;
    r.head_data = '0;
    r.status    = spq_pkg::ST_OK;
    case (mode)
      spq_pkg::MODE_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // Land behind every entry of lower or equal priority: ties stay FIFO.
          slot = 0;
          while (slot < shadow_count && shadow_prio[slot] <= prio) slot++;
          for (int k = shadow_count; k > slot; k--) begin
            shadow_prio[k] = shadow_prio[k-1];
            shadow_data[k] = shadow_data[k-1];
          end
          shadow_prio[slot] = prio;
          shadow_data[slot] = data;
          shadow_count++;
        end
      end
      spq_pkg::MODE_POP, spq_pkg::MODE_FRONT: begin
        if (shadow_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.head_data = shadow_data[0];
          if (mode == spq_pkg::MODE_POP) begin
            for (int k = 1; k < shadow_count; k++) begin
              shadow_prio[k-1] = shadow_prio[k];
              shadow_data[k-1] = shadow_data[k];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[OCC_BITS-1:0];
    return r;
  endfunction

  // Watch both channels at every edge: check taken results against the oldest
  // expectation, then predict the result of a newly accepted item. Values read
  // here are the ones settled before the edge.
  always @(posedge clk) begin
    op_result_t exp_r;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected: head %h status %0d occ %0d",
                   $realtime, out_head_data, out_status, out_occupancy);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_head_data !== exp_r.head_data) begin
            error_count++;
            $display("%0t: head_data expected %h actual %h",
                     $realtime, exp_r.head_data, out_head_data);
          end
          if (out_status !== exp_r.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d",
                     $realtime, exp_r.status, out_status);
          end
          if (out_occupancy !== exp_r.occupancy) begin
            error_count++;
            $display("%0t: occupancy expected %0d actual %0d",
                     $realtime, exp_r.occupancy, out_occupancy);
          end
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        pending_results.push_back(apply_queue_op(in_mode, in_priority_req, in_payload));
      end
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles per item, or take a requested
  // long hold-off, then stay ready until one result is taken.
  initial begin
    int stall;
    forever begin
      if (hold_off_req > 0) begin
        stall = hold_off_req;
        hold_off_req = 0;
      end else begin
        stall = take_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Offer one item after an optional gap and return at the edge it is accepted.
  // Valid is left high so a back-to-back item follows without a bubble.
  task automatic send_op(logic [1:0] mode, logic [PRIORITY_BITS-1:0] prio,
                         logic [DATA_BITS-1:0] data);
    int gap;
    gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_priority_req <= prio;
    in_payload      <= data;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 99);
    // Mostly a narrow range so ties are common, some full range, some extremes.
    if (sel < 50) return PRIORITY_BITS'($urandom_range(0, 7));
    if (sel < 90) return PRIORITY_BITS'($urandom);
    return (sel < 95) ? '0 : '1;
  endfunction

  task automatic test_empty_queue();
    send_op(spq_pkg::MODE_POP,   '1, '1);
    send_op(spq_pkg::MODE_FRONT, '0, '0);
    send_op(MODE_NOP,            '1, '1);
  endtask

  // Fill with extremes and heavy ties, then push into the full row.
  task automatic test_fill_and_overflow();
    logic [PRIORITY_BITS-1:0] fill_prio [DEPTH];
    fill_prio = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                  16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000,
                  16'h0005, 16'h0005, 16'h0005, 16'h0000};
    send_op(spq_pkg::MODE_PUSH, fill_prio[0], '1);
    send_op(spq_pkg::MODE_PUSH, fill_prio[1], '0);
    for (int i = 2; i < DEPTH; i++) begin
      send_op(spq_pkg::MODE_PUSH, fill_prio[i],
              {8'(i), 24'hA5C3_96} ^ DATA_BITS'($urandom));
    end
    send_op(spq_pkg::MODE_PUSH, '0, 32'h5A5A_0001);
    send_op(MODE_NOP, '0, '0);
    send_op(spq_pkg::MODE_FRONT, '1, '1);
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_hold_off();
    send_idle_en = 1'b0;
    take_idle_en = 1'b0;
    hold_off_req = HOLD_OFF_LEN;
    for (int i = 0; i < 24; i++) begin
      send_op((i % 3 == 0) ? spq_pkg::MODE_PUSH :
              ((i % 3 == 1) ? spq_pkg::MODE_POP : spq_pkg::MODE_FRONT),
              pick_priority(), DATA_BITS'($urandom));
    end
    send_idle_en = 1'b1;
    take_idle_en = 1'b1;
  endtask

  // Pause the input until everything has come back, then resume.
  task automatic test_pause_until_drained();
    wait_results_drained();
    send_op(spq_pkg::MODE_FRONT, '0, '0);
    send_op(spq_pkg::MODE_PUSH, pick_priority(), DATA_BITS'($urandom));
  endtask

  // Phases biased toward filling, draining or a balanced mix, so the row
  // swings between empty and full; idling changes from phase to phase.
  task automatic test_random_ops(int count);
    int push_pct;
    int sel;
    logic [1:0] mode;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
        send_idle_en = ($urandom_range(0, 3) != 0);
        take_idle_en = ($urandom_range(0, 3) != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        mode = MODE_NOP;
      end else if ($urandom_range(0, 99) < push_pct) begin
        mode = spq_pkg::MODE_PUSH;
      end else begin
        mode = ($urandom_range(0, 3) == 0) ? spq_pkg::MODE_FRONT : spq_pkg::MODE_POP;
      end
      send_op(mode, pick_priority(), DATA_BITS'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_and_overflow();
    test_output_hold_off();
    test_pause_until_drained();
    test_random_ops(RANDOM_ITEMS);

    // Wait out the last results; the watchdog catches a hang.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_top.sv
tb/stable_priority_queue_top_test.sv
